@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every edge
`define ASSERT_CLK(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ptss_pkg.sv @@
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types and constants of the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int OP_W        = 3;
  localparam int SLOT_W      = 5;
  localparam int PERIOD_W    = 32;
  localparam int KIND_W      = 3;
  localparam int TOTAL_W     = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - KIND_W - SLOT_W - TOTAL_W;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    RK_CREATED    = 3'd0,
    RK_FULL       = 3'd1,
    RK_STATUS_SET = 3'd2,
    RK_BAD_SLOT   = 3'd3,
    RK_DUE        = 3'd4,
    RK_NONE_DUE   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_SUSPENDED = 2'd2,
    ST_DELETED   = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } result_t;

endpackage

@@ rtl/ptss_out_reg.sv @@
// ----------------------------------------------------------------------------
// ptss_out_reg
// Output register between the scheduler core and the result stream.
// ----------------------------------------------------------------------------
module ptss_out_reg import ptss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    push_ready,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_res
);

  logic    ov;
  result_t res;

  assign push_ready = !ov || m_ready;
  assign m_valid    = ov;
  assign m_res      = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (push_ready) begin
      ov <= push;
    end
    if (push && push_ready) begin
      res <= push_res;
    end
  end

endmodule

@@ rtl/ptss_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptss_ctrl
// Slot table memory and the sequencer that reads, updates and writes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptss_ctrl import ptss_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [PERIOD_W-1:0] in_period,
  output logic                push,
  output result_t             push_res,
  input  logic                push_ready
);

  localparam int SW   = $clog2(SLOT_COUNT + 2);
  localparam int AW   = $clog2(SLOT_COUNT + 1);
  localparam int CNTW = $clog2(SLOT_COUNT + 1);
  localparam int CMPW = (SW > SLOT_W) ? SW : SLOT_W;
  localparam logic [SW-1:0]   END_MARK = SW'(SLOT_COUNT + 1);
  localparam logic [SW-1:0]   HEAD     = '0;
  localparam logic [SW-1:0]   SLOT_MAX = SW'(SLOT_COUNT);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(SLOT_COUNT);

  typedef struct packed {
    logic [SW-1:0]       link;
    status_t             status;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] last_fire;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STAT_WR,
    S_CR_LINK,
    S_CR_NEW,
    S_WALK,
    S_FINISH
  } state_t;

  entry_t table_mem [1:SLOT_COUNT];
  entry_t rd_data;

  state_t              state;
  opcode_t             op;
  logic [SLOT_W-1:0]   req_slot;
  logic [PERIOD_W-1:0] req_period;
  logic [AW-1:0]       new_slot;
  logic [SW-1:0]       cur;
  logic [SW-1:0]       prev;
  entry_t              prev_e;
  logic [SW-1:0]       head;
  logic [SW-1:0]       tail;
  logic [SLOT_COUNT:1] occ;
  logic [CNTW-1:0]     occupied;
  logic [CNTW-1:0]     del_count;
  logic [PERIOD_W-1:0] time_now;
  logic                pend_valid;
  result_t             pend;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic          in_range;
  logic          slot_ok;
  logic          full;
  logic [AW-1:0] free_slot;
  logic          due;
  logic          stall;
  logic          advance;
  logic          walk_end;
  logic [SW-1:0] nx;
  entry_t        cur_upd;
  status_t       new_status;

  assign in_ready = (state == S_IDLE);
  assign in_range = (in_slot != '0) && (CMPW'(in_slot) <= CMPW'(SLOT_COUNT));
  assign slot_ok  = in_range && occ[AW'(in_slot)];
  assign full     = (occupied == CNT_FULL);

  always_comb begin
    free_slot = '0;
    for (int i = SLOT_COUNT; i >= 1; i--) begin
      if (!occ[i]) begin
        free_slot = AW'(i);
      end
    end
  end

  always_comb begin
    unique case (op)
      OP_DELETE:  new_status = ST_DELETED;
      OP_SUSPEND: new_status = ST_SUSPENDED;
      default:    new_status = ST_RUNNING;
    endcase
  end

  // walk step: decide on the entry that came back from the table
  assign nx       = rd_data.link;
  assign walk_end = (nx == HEAD) || (nx > SLOT_MAX);
  assign due      = (rd_data.status == ST_RUNNING) &&
                    ((time_now - rd_data.last_fire) >= rd_data.period);
  assign stall    = due && pend_valid && !push_ready;
  assign advance  = (state == S_WALK) && !stall;

  always_comb begin
    cur_upd = rd_data;
    if (due) begin
      cur_upd.last_fire = time_now;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_data;
    mem_re    = 1'b0;
    mem_raddr = '0;
    push      = 1'b0;
    push_res  = pend;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode_t'(in_op))
            OP_TICK: begin
              mem_re    = (head != END_MARK);
              mem_raddr = AW'(head);
            end
            OP_CREATE: begin
              mem_re    = !full && (tail != HEAD);
              mem_raddr = AW'(tail);
            end
            OP_DELETE, OP_SUSPEND, OP_RESUME: begin
              mem_re    = slot_ok;
              mem_raddr = AW'(in_slot);
            end
            default: ;
          endcase
        end
      end
      S_STAT_WR: begin
        mem_we           = 1'b1;
        mem_waddr        = AW'(req_slot);
        mem_wdata.status = new_status;
      end
      S_CR_LINK: begin
        mem_we         = 1'b1;
        mem_waddr      = AW'(tail);
        mem_wdata.link = SW'(new_slot);
      end
      S_CR_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = new_slot;
        mem_wdata = '{link: END_MARK, status: ST_RUNNING, period: req_period,
                      last_fire: '0};
      end
      S_WALK: begin
        if (advance) begin
          if (due) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cur);
            mem_wdata = cur_upd;
            push      = pend_valid;
          end else if ((rd_data.status == ST_DELETED) && (prev != HEAD)) begin
            mem_we         = 1'b1;
            mem_waddr      = AW'(prev);
            mem_wdata      = prev_e;
            mem_wdata.link = nx;
          end
          mem_re    = !walk_end;
          mem_raddr = AW'(nx);
        end
      end
      S_FINISH: begin
        push = 1'b1;
        if (!pend_valid) begin
          push_res = '{kind: RK_NONE_DUE, slot: '0, total: TOTAL_W'(occupied), last: 1'b0};
        end
        push_res.last = 1'b1;
      end
      default: ;
    endcase
  end

  // one write and one registered read per cycle; the sequencer never reads
  // an entry in the cycle it is written
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= table_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= END_MARK;
      tail       <= HEAD;
      occ        <= '0;
      occupied   <= '0;
      del_count  <= '0;
      time_now   <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= opcode_t'(in_op);
            req_slot   <= in_slot;
            req_period <= in_period;
            new_slot   <= free_slot;
            unique case (opcode_t'(in_op))
              OP_TICK: begin
                time_now   <= time_now + 1'b1;
                occupied   <= occupied - del_count;
                del_count  <= '0;
                pend_valid <= 1'b0;
                cur        <= head;
                prev       <= HEAD;
                state      <= (head == END_MARK) ? S_FINISH : S_WALK;
              end
              OP_CREATE: begin
                if (full) begin
                  pend_valid <= 1'b1;
                  pend       <= '{kind: RK_FULL, slot: '0, total: TOTAL_W'(occupied),
                                  last: 1'b0};
                  state      <= S_FINISH;
                end else if (tail == HEAD) begin
                  state <= S_CR_NEW;
                end else begin
                  state <= S_CR_LINK;
                end
              end
              OP_DELETE, OP_SUSPEND, OP_RESUME: begin
                if (slot_ok) begin
                  state <= S_STAT_WR;
                end else begin
                  pend_valid <= 1'b1;
                  pend       <= '{kind: RK_BAD_SLOT, slot: in_slot,
                                  total: TOTAL_W'(occupied), last: 1'b0};
                  state      <= S_FINISH;
                end
              end
              default: ;
            endcase
          end
        end
        S_STAT_WR: begin
          if ((rd_data.status != ST_DELETED) && (new_status == ST_DELETED)) begin
            del_count <= del_count + 1'b1;
          end else if ((rd_data.status == ST_DELETED) && (new_status != ST_DELETED)) begin
            del_count <= del_count - 1'b1;
          end
          pend_valid <= 1'b1;
          pend       <= '{kind: RK_STATUS_SET, slot: req_slot,
                          total: TOTAL_W'(occupied), last: 1'b0};
          state      <= S_FINISH;
        end
        S_CR_LINK: begin
          state <= S_CR_NEW;
        end
        S_CR_NEW: begin
          if (tail == HEAD) begin
            head <= SW'(new_slot);
          end
          occ[new_slot] <= 1'b1;
          occupied      <= occupied + 1'b1;
          tail          <= SW'(new_slot);
          pend_valid    <= 1'b1;
          pend          <= '{kind: RK_CREATED, slot: SLOT_W'(new_slot),
                             total: TOTAL_W'(occupied + 1'b1), last: 1'b0};
          state         <= S_FINISH;
        end
        S_WALK: begin
          if (advance) begin
            if (due) begin
              pend_valid <= 1'b1;
              pend       <= '{kind: RK_DUE, slot: SLOT_W'(cur),
                              total: TOTAL_W'(occupied), last: 1'b0};
            end
            if (rd_data.status == ST_DELETED) begin
              occ[AW'(cur)] <= 1'b0;
              prev_e.link   <= nx;
              if (prev == HEAD) begin
                head <= nx;
              end
              if (cur == tail) begin
                tail <= prev;
              end
            end else begin
              prev   <= cur;
              prev_e <= cur_upd;
            end
            if (walk_end) begin
              state <= S_FINISH;
            end else begin
              cur <= nx;
            end
          end
        end
        S_FINISH: begin
          if (push_ready) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_idle_count, state == S_IDLE, $countones(occ) == int'(occupied), "occupancy count out of step")
  `ASSERT_CLK(a_del_bound, del_count <= occupied, "more slots marked deleted than occupied")
  `ASSERT_CLK(a_list_ends, (head == END_MARK) == (tail == HEAD), "head and tail disagree on empty list")
  `ASSERT_IMP(a_push_ok, push && (state == S_WALK), push_ready, "walk pushed into a full output")
  `ASSERT_NXT(a_finish, (state == S_FINISH) && push_ready, (state == S_IDLE) && !pend_valid, "final transfer did not close the item")

endmodule

@@ rtl/periodic_task_slot_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_core
// Task slot table with creation-order list, tick-driven due reporting.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream, one transfer per command; results leave
// on the m_ stream, m_tlast marking the final result of each command.
// Create, delete, suspend and resume give one result each; a tick gives one
// result per due task in list order, or a single none-due result.
// Path from command transfer to the result in the output register: status
// commands pass S_STAT_WR and S_FINISH; create passes S_CR_NEW and S_FINISH
// into an empty list, with S_CR_LINK ahead of them otherwise. A tick on an
// empty list goes straight to S_FINISH; a walk holds each due result until
// the next due task turns up, so the first one is pushed when the second
// due task is read, or from S_FINISH when at most one task is due. A tick
// walks the linked tasks with one table entry read per cycle through the
// single read port of the slot table, unless the output stalls it. Unknown
// opcodes are taken and dropped. A new command is taken while a finished
// result still waits in the output register. When the receiver stalls, a
// tick walk holds on the next due task until the output register frees.
// Reset empties the table and the list, clears time and counts, and drops
// any pending result; no clearing pass is needed, so commands are taken
// from the first cycle after reset.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler_core import ptss_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // opcode, task_slot, task_period
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // result_kind, result_slot, task_total
  output logic                   m_tlast
);

  logic    push;
  logic    push_ready;
  result_t push_res;
  result_t m_res;

  ptss_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tdata[OP_W-1:0]),
    .in_slot    (s_tdata[OP_W+SLOT_W-1:OP_W]),
    .in_period  (s_tdata[OP_W+SLOT_W+PERIOD_W-1:OP_W+SLOT_W]),
    .push       (push),
    .push_res   (push_res),
    .push_ready (push_ready)
  );

  ptss_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_res   (push_res),
    .push_ready (push_ready),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_res      (m_res)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, m_res.total, m_res.slot, m_res.kind};
  assign m_tlast = m_res.last;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the periodic task slot scheduler and checks every
// result transfer against a model of the slot table, kept in a scoreboard.
// A short directed sequence opens the run; random commands follow in phases
// that fill the table, churn it and tick it, with bursty input, a stalling
// receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import ptss_pkg::*;

  localparam int SLOT_COUNT    = SLOT_COUNT_DEF;
  localparam int SLOT_MAX      = (1 << SLOT_W) - 1;
  localparam int RANDOM_ITEMS  = 195;
  localparam int HOLD_AFTER    = 70;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 2 * (SLOT_COUNT + 4);
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_RESUME + 1);
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = '1;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MASK} rx_mode_t;

  class task_table_scoreboard;
    localparam int NSLOT    = SLOT_COUNT_DEF;
    localparam int END_MARK = NSLOT + 1;

    int                  link_nxt  [0:NSLOT];
    status_t             state_of  [0:NSLOT];
    logic [PERIOD_W-1:0] period_of [0:NSLOT];
    logic [PERIOD_W-1:0] fired_at  [0:NSLOT];
    logic [PERIOD_W-1:0] now;
    int                  occupied;
    result_t             pending_results [$];
    int                  mismatches;
    int                  checked;
    int                  longest_run;
    int                  kind_seen [8];

    function new();
      for (int i = 0; i <= NSLOT; i++) begin
        link_nxt[i]  = END_MARK;
        state_of[i]  = ST_EMPTY;
        period_of[i] = '0;
        fired_at[i]  = '0;
      end
      now         = '0;
      occupied    = 0;
      mismatches  = 0;
      checked     = 0;
      longest_run = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void add_result(kind_t kind, int slot);
      result_t r;
      r.kind  = kind;
      r.slot  = slot[SLOT_W-1:0];
      r.total = occupied[TOTAL_W-1:0];
      r.last  = 1'b0;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted command to the table and queue what it should produce
    function void note_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                               logic [PERIOD_W-1:0] period);
      int cur;
      int prev;
      int nx;
      int tail;
      int free_slot;
      int first;
      logic [PERIOD_W-1:0] elapsed;
      int due_slots [$];
      first = pending_results.size();
      case (op)
        OP_TICK: begin
          now = now + 1'b1;
          cur = link_nxt[0];
          for (int g = 0; g < NSLOT && cur <= NSLOT && cur != 0; g++) begin
            elapsed = now - fired_at[cur];
            if (state_of[cur] == ST_RUNNING && elapsed >= period_of[cur]) begin
              fired_at[cur] = now;
              due_slots.push_back(cur);
            end
            cur = link_nxt[cur];
          end
          // free the slots marked deleted, keeping list order
          prev = 0;
          cur  = link_nxt[0];
          for (int g = 0; g < NSLOT && cur <= NSLOT && cur != 0; g++) begin
            nx = link_nxt[cur];
            if (state_of[cur] == ST_DELETED) begin
              link_nxt[prev] = nx;
              link_nxt[cur]  = END_MARK;
              state_of[cur]  = ST_EMPTY;
              if (occupied > 0) occupied--;
            end else begin
              prev = cur;
            end
            cur = nx;
          end
          if (due_slots.size() == 0) add_result(RK_NONE_DUE, 0);
          foreach (due_slots[i]) add_result(RK_DUE, due_slots[i]);
          if (due_slots.size() > longest_run) longest_run = due_slots.size();
        end
        OP_CREATE: begin
          free_slot = 0;
          if (occupied < NSLOT) begin
            for (int s = 1; s <= NSLOT; s++) begin
              if (state_of[s] == ST_EMPTY && free_slot == 0) free_slot = s;
            end
          end
          if (free_slot == 0) begin
            add_result(RK_FULL, 0);
          end else begin
            tail = 0;
            for (int g = 0; g < NSLOT && link_nxt[tail] <= NSLOT && link_nxt[tail] != 0; g++)
              tail = link_nxt[tail];
            link_nxt[tail]      = free_slot;
            link_nxt[free_slot] = END_MARK;
            state_of[free_slot] = ST_RUNNING;
            period_of[free_slot] = period;
            fired_at[free_slot]  = '0;
            occupied++;
            add_result(RK_CREATED, free_slot);
          end
        end
        OP_DELETE, OP_SUSPEND, OP_RESUME: begin
          if (slot >= 1 && slot <= NSLOT && state_of[slot] != ST_EMPTY) begin
            if (op == OP_DELETE) state_of[slot] = ST_DELETED;
            else if (op == OP_SUSPEND) state_of[slot] = ST_SUSPENDED;
            else state_of[slot] = ST_RUNNING;
            add_result(RK_STATUS_SET, slot);
          end else begin
            add_result(RK_BAD_SLOT, slot);
          end
        end
        default: ;
      endcase
      if (pending_results.size() > first) pending_results[$].last = 1'b1;
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [TOTAL_W-1:0] total, logic last);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: kind %0d slot %0d total %0d last %0d",
                   kind, slot, total, last);
        return;
      end
      want = pending_results.pop_front();
      kind_seen[want.kind]++;
      if (kind !== want.kind || slot !== want.slot || total !== want.total
          || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d slot %0d total %0d last %0d, got %0d %0d %0d %0d",
                   want.kind, want.slot, want.total, want.last, kind, slot, total, last);
      end
    endfunction
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tready = 1'b0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  task_table_scoreboard table_sb;
  int          commands_taken = 0;
  int          burst_left     = 0;
  bit          held_off       = 1'b0;
  int unsigned cycle_count    = 0;

  periodic_task_slot_scheduler_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      table_sb.check_result(m_tdata[KIND_W-1:0], m_tdata[KIND_W+SLOT_W-1:KIND_W],
                            m_tdata[KIND_W+SLOT_W+TOTAL_W-1:KIND_W+SLOT_W], m_tlast);
  end

  // sender: bursts of transfers with random gaps in between
  task automatic send_command(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                              input logic [PERIOD_W-1:0] period);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
    end
    s_tdata  <= {period, slot, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    table_sb.note_command(op, slot, period);
    commands_taken++;
    burst_left--;
  endtask

  // receiver: stall pattern changes after each random span; one long hold-off
  initial begin : receiver
    rx_mode_t   mode;
    int         span;
    logic [7:0] mask;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && commands_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 60);
      mask = 8'($urandom) | 8'h01;
      repeat (span) begin
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            m_tready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int tick_pct   [4];
    int create_pct [4];
    int phase;
    int roll;
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    tick_pct   = '{20, 35, 30, 35};
    create_pct = '{60, 25, 15, 25};
    table_sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table, bad slots, unknown opcodes
    send_command(OP_TICK, 0, 0);
    send_command(OP_DELETE, 0, 0);
    send_command(OP_SUSPEND, SLOT_COUNT + 1, 0);
    send_command(OP_RESUME, SLOT_MAX, PERIOD_MAX);
    send_command(OP_SUSPEND, 3, 0);
    send_command(OP_FIRST_UNUSED, 1, 0);
    send_command(OP_FIRST_UNUSED + 1, 2, 0);
    send_command(OP_LAST_UNUSED, SLOT_MAX, PERIOD_MAX);
    // zero, largest and unit periods
    send_command(OP_CREATE, 0, 0);
    send_command(OP_CREATE, SLOT_MAX, PERIOD_MAX);
    send_command(OP_CREATE, 0, 1);
    send_command(OP_TICK, 0, 0);
    send_command(OP_SUSPEND, 3, 0);
    send_command(OP_TICK, 0, 0);
    send_command(OP_RESUME, 3, 0);
    // deleted slot may be suspended and resumed before the sweep
    send_command(OP_DELETE, 1, 0);
    send_command(OP_SUSPEND, 1, 0);
    send_command(OP_RESUME, 1, 0);
    send_command(OP_DELETE, 2, 0);
    send_command(OP_TICK, 0, 0);
    send_command(OP_CREATE, 0, 2);
    send_command(OP_TICK, 0, 0);
    send_command(OP_DELETE, 3, 0);
    send_command(OP_CREATE, 0, 3);
    send_command(OP_TICK, 0, 0);

    // fill, mixed, churn, mixed
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase = i * 4 / RANDOM_ITEMS;
      roll  = $urandom_range(0, 99);
      if (roll < tick_pct[phase]) begin
        op = OP_TICK;
      end else if (roll < tick_pct[phase] + create_pct[phase]) begin
        op = OP_CREATE;
      end else if (roll < 95) begin
        case ($urandom_range(0, (phase == 2) ? 3 : 2))
          0:       op = OP_SUSPEND;
          1:       op = OP_RESUME;
          default: op = OP_DELETE;
        endcase
      end else begin
        op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end
      if ((op == OP_DELETE || op == OP_SUSPEND || op == OP_RESUME)
          && $urandom_range(0, 9) != 0)
        slot = SLOT_W'($urandom_range(1, SLOT_COUNT));
      else
        slot = SLOT_W'($urandom_range(0, SLOT_MAX));
      case ($urandom_range(0, 9))
        0:       period = '0;
        1, 2:    period = $urandom;
        3:       period = PERIOD_MAX - $urandom_range(0, 3);
        default: period = $urandom_range(1, 5);
      endcase
      send_command(op, slot, period);
    end
    s_tvalid <= 1'b0;

    while (table_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d created, %0d table full, %0d status set, %0d bad slot",
             commands_taken, table_sb.kind_seen[RK_CREATED], table_sb.kind_seen[RK_FULL],
             table_sb.kind_seen[RK_STATUS_SET], table_sb.kind_seen[RK_BAD_SLOT]);
    $display("ticks gave %0d due and %0d none-due results, longest run %0d; %0d results checked",
             table_sb.kind_seen[RK_DUE], table_sb.kind_seen[RK_NONE_DUE],
             table_sb.longest_run, table_sb.checked);
    if (table_sb.mismatches == 0 && table_sb.pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ periodic_task_slot_scheduler_core.f @@
+incdir+rtl
rtl/ptss_pkg.sv
rtl/ptss_out_reg.sv
rtl/ptss_ctrl.sv
rtl/periodic_task_slot_scheduler_core.sv
tb/testbench.sv
